@@ hw/rtl/fpd_pkg.sv @@
// shared types and constants for the frame packet deframer
package fpd_pkg;

  // record header length and header byte positions
  localparam int HEADER_BYTES = 8;
  localparam int HDR_POS_W    = $clog2(HEADER_BYTES);

  localparam logic [HDR_POS_W-1:0] HDR_SIZE_LO  = HDR_POS_W'(0);
  localparam logic [HDR_POS_W-1:0] HDR_SIZE_HI  = HDR_POS_W'(1);
  localparam logic [HDR_POS_W-1:0] HDR_IDENT_B0 = HDR_POS_W'(2);
  localparam logic [HDR_POS_W-1:0] HDR_IDENT_B1 = HDR_POS_W'(3);
  localparam logic [HDR_POS_W-1:0] HDR_IDENT_B2 = HDR_POS_W'(4);
  localparam logic [HDR_POS_W-1:0] HDR_IDENT_B3 = HDR_POS_W'(5);
  localparam logic [HDR_POS_W-1:0] HDR_FRAGMENT = HDR_POS_W'(6);
  localparam logic [HDR_POS_W-1:0] HDR_LAST_POS = HDR_POS_W'(HEADER_BYTES - 1);

  // result kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_TRUNCATED = 1'b1;

  // input transaction payload
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_item_t;

  // result transaction payload
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] packet_ident;
    logic [7:0]  fragment_number;
    logic [7:0]  last_fragment_mark;
    logic        first_of_packet;
    logic        last_of_packet;
  } result_item_t;

endpackage

@@ hw/rtl/fpd_stream_if.sv @@
// valid/ready stream channel with a typed payload
interface fpd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/frame_packet_deframer_core.sv @@
// frame packet deframer: splits a byte stream into tagged payload bytes and truncation results
// the result of an accepted byte is registered in the output register
// throughput: one byte per cycle; a byte is taken whenever the output register
//   is empty or being drained in the same cycle
// reset: synchronous rst returns the parser to the header phase and empties
//   the output register; the last byte of each frame does the same for the parser
module frame_packet_deframer_core (
  input  logic clk,
  input  logic rst,
  fpd_stream_if.sink   frame_chan,
  fpd_stream_if.source result_chan
);
  import fpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DRAIN   = 2'd2
  } phase_t;

  // parser state
  phase_t                 parse_phase, parse_phase_next;
  logic [HDR_POS_W-1:0]   header_position, header_position_next;
  logic [15:0]            record_size, record_size_next;
  logic [31:0]            ident_accumulator, ident_accumulator_next;
  logic [7:0]             fragment_held, fragment_held_next;
  logic [7:0]             last_mark_held, last_mark_held_next;
  logic [15:0]            bytes_remaining, bytes_remaining_next;

  // output register
  logic                   out_valid, out_valid_next;
  result_item_t           out_item, out_item_next;

  logic                   accept;
  logic                   produce;
  logic                   incomplete;
  logic                   first_byte, last_byte;
  logic [7:0]             b;
  logic                   fend;

  assign b    = frame_chan.payload.frame_byte;
  assign fend = frame_chan.payload.frame_end;

  // take a byte when the output register is free or draining
  assign frame_chan.ready  = !out_valid || result_chan.ready;
  assign accept            = frame_chan.valid && frame_chan.ready;
  assign result_chan.valid = out_valid;
  assign result_chan.payload = out_item;

  assign first_byte = (bytes_remaining == record_size);
  assign last_byte  = (bytes_remaining <= 16'd1);

  // per-byte parse step
  always_comb begin
    parse_phase_next       = parse_phase;
    header_position_next   = header_position;
    record_size_next       = record_size;
    ident_accumulator_next = ident_accumulator;
    fragment_held_next     = fragment_held;
    last_mark_held_next    = last_mark_held;
    bytes_remaining_next   = bytes_remaining;
    produce                = 1'b0;
    incomplete             = 1'b0;
    out_item_next          = '0;

    case (parse_phase)
      PH_HEADER: begin
        incomplete = 1'b1;
        case (header_position)
          HDR_SIZE_LO:  record_size_next = {8'd0, b};
          HDR_SIZE_HI: begin
            record_size_next = {b, record_size[7:0]};
            if ({b, record_size[7:0]} == 16'd0) begin
              parse_phase_next = PH_DRAIN;
              incomplete       = 1'b0;
            end
          end
          HDR_IDENT_B0: ident_accumulator_next = {24'd0, b};
          HDR_IDENT_B1: ident_accumulator_next[15:8]  = b;
          HDR_IDENT_B2: ident_accumulator_next[23:16] = b;
          HDR_IDENT_B3: ident_accumulator_next[31:24] = b;
          HDR_FRAGMENT: fragment_held_next = b;
          default:      last_mark_held_next = b;
        endcase
        if (parse_phase_next == PH_HEADER) begin
          if (header_position == HDR_LAST_POS) begin
            bytes_remaining_next = record_size;
            parse_phase_next     = PH_PAYLOAD;
            header_position_next = '0;
          end else begin
            header_position_next = header_position + HDR_POS_W'(1);
          end
        end
        // frame cut inside a header
        if (fend && incomplete) begin
          produce                   = 1'b1;
          out_item_next.result_kind = KIND_TRUNCATED;
        end
      end
      PH_PAYLOAD: begin
        produce = 1'b1;
        if (fend && !last_byte) begin
          out_item_next.result_kind = KIND_TRUNCATED;
        end else begin
          out_item_next.result_kind        = KIND_PAYLOAD;
          out_item_next.payload_byte       = b;
          out_item_next.packet_ident       = ident_accumulator;
          out_item_next.fragment_number    = fragment_held;
          out_item_next.last_fragment_mark = last_mark_held;
          out_item_next.first_of_packet    = first_byte;
          out_item_next.last_of_packet     = last_byte;
        end
        if (last_byte) begin
          bytes_remaining_next = '0;
          parse_phase_next     = PH_HEADER;
          header_position_next = '0;
        end else begin
          bytes_remaining_next = bytes_remaining - 16'd1;
        end
      end
      default: begin
        // draining after the terminator record
      end
    endcase

    // frame end restarts the parser
    if (fend) begin
      parse_phase_next     = PH_HEADER;
      header_position_next = '0;
    end
  end

  // output register valid
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = produce;
    end else if (result_chan.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HEADER;
      header_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        parse_phase     <= parse_phase_next;
        header_position <= header_position_next;
      end
    end
  end

  // header fields, counters and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      record_size       <= record_size_next;
      ident_accumulator <= ident_accumulator_next;
      fragment_held     <= fragment_held_next;
      last_mark_held    <= last_mark_held_next;
      bytes_remaining   <= bytes_remaining_next;
      if (produce) begin
        out_item <= out_item_next;
      end
    end
  end

endmodule
